[hw/rtl/bch_pkg.sv]
// shared types, constants and the syndrome correction table for the bch(15,7) codec
package bch_pkg;

    localparam int CODE_N     = 15;
    localparam int DATA_W     = 7;
    localparam int REM_W      = 8;
    localparam int CELL_COUNT = CODE_N - REM_W;
    localparam int SYN_COUNT  = 1 << REM_W;

    // g(x) = x^8 + x^7 + x^6 + x^4 + 1
    localparam logic [REM_W:0]   GEN_POLY = 9'h1D1;
    localparam logic [REM_W-1:0] GEN_LOW  = GEN_POLY[REM_W-1:0];

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // data carried along the cell chain
    typedef struct packed {
        op_t                op;
        logic [CODE_N-1:0]  word;
        logic [REM_W-1:0]   rem;
        logic [DATA_W-1:0]  pend;
    } stage_t;

    typedef struct packed {
        logic              unc;
        logic [1:0]        fixed;
        logic [CODE_N-1:0] pat;
    } corr_entry_t;

    typedef corr_entry_t [SYN_COUNT-1:0] corr_table_t;

    typedef struct packed {
        logic [CODE_N-1:0] word_out;
        logic              uncorrectable;
        logic [1:0]        errors_fixed;
    } result_t;

    function automatic logic [REM_W-1:0] poly_rem(input logic [CODE_N-1:0] w);
        logic [CODE_N-1:0] r;
        logic [CODE_N-1:0] gp;
        r  = w;
        gp = CODE_N'(GEN_POLY);
        for (int b = CODE_N - 1; b >= REM_W; b--)
        begin
            if (r[b])
            begin
                r = r ^ (gp << (b - REM_W));
            end
        end
        return r[REM_W-1:0];
    endfunction

    function automatic corr_table_t build_corr_table();
        corr_table_t       t;
        logic [REM_W-1:0]  s;
        logic [CODE_N-1:0] one;
        one = CODE_N'(1);
        for (int k = 0; k < SYN_COUNT; k++)
        begin
            t[k].unc   = 1'b1;
            t[k].fixed = 2'd0;
            t[k].pat   = '0;
        end
        // double errors first so a single error wins any syndrome they share
        for (int i = 0; i < CODE_N; i++)
        begin
            for (int j = i + 1; j < CODE_N; j++)
            begin
                s = poly_rem(one << i) ^ poly_rem(one << j);
                t[s].unc   = 1'b0;
                t[s].fixed = 2'd2;
                t[s].pat   = (one << i) | (one << j);
            end
        end
        for (int i = 0; i < CODE_N; i++)
        begin
            s = poly_rem(one << i);
            t[s].unc   = 1'b0;
            t[s].fixed = 2'd1;
            t[s].pat   = one << i;
        end
        t[0].unc   = 1'b0;
        t[0].fixed = 2'd0;
        t[0].pat   = '0;
        return t;
    endfunction

    localparam corr_table_t CORR_TABLE = build_corr_table();

endpackage

[hw/rtl/bch_if.sv]
// valid/ready channel interfaces for the codec input and output
interface bch_in_if;
    import bch_pkg::*;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CODE_N-1:0] word_in;

    modport source (output valid, output operation, output word_in, input ready);
    modport sink   (input valid, input operation, input word_in, output ready);
endinterface

interface bch_out_if;
    import bch_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_N-1:0] word_out;
    logic              uncorrectable;
    logic [1:0]        errors_fixed;

    modport source (output valid, output word_out, output uncorrectable,
                    output errors_fixed, input ready);
    modport sink   (input valid, input word_out, input uncorrectable,
                    input errors_fixed, output ready);
endinterface

[hw/rtl/bch_cell.sv]
// one polynomial division step: shift in one bit and reduce by g(x)
module bch_cell
    import bch_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        data_next      = in_data;
        data_next.rem  = {in_data.rem[REM_W-2:0], in_data.pend[DATA_W-1]}
                         ^ (in_data.rem[REM_W-1] ? GEN_LOW : '0);
        data_next.pend = {in_data.pend[DATA_W-2:0], 1'b0};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/bch_corr.sv]
// syndrome lookup and correction (decode) or codeword assembly (encode), and output register
module bch_corr
    import bch_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  stage_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic              valid_reg;
    result_t           res_reg;
    result_t           res_next;
    corr_entry_t       entry;
    logic [CODE_N-1:0] fixed_word;

    always_comb
    begin
        entry      = CORR_TABLE[in_data.rem];
        fixed_word = in_data.word ^ entry.pat;
        res_next   = '0;
        case (in_data.op)
            OP_ENCODE:
            begin
                res_next.word_out = {in_data.word[CODE_N-1:REM_W], in_data.rem};
            end
            OP_DECODE:
            begin
                if (entry.unc)
                begin
                    res_next.uncorrectable = 1'b1;
                end
                else
                begin
                    res_next.word_out     = CODE_N'(fixed_word[CODE_N-1:REM_W]);
                    res_next.errors_fixed = entry.fixed;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= res_next;
        end
    end

    a_unc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.uncorrectable |->
            out_data.errors_fixed == 2'd0 && out_data.word_out == '0)
        else $error("uncorrectable result carries data");

    a_fixed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.errors_fixed != 2'd3)
        else $error("errors_fixed out of range");

    a_clean_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_DECODE && in_data.rem == '0 |=>
            out_valid && !out_data.uncorrectable && out_data.errors_fixed == 2'd0
            && out_data.word_out == CODE_N'($past(in_data.word[CODE_N-1:REM_W])))
        else $error("clean word not passed through");

    a_encode_flags: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_ENCODE |=>
            !out_data.uncorrectable && out_data.errors_fixed == 2'd0)
        else $error("encode result has decode flags");

endmodule

[hw/rtl/bch_15_7_codec_core.sv]
// top level of the bch(15,7) double error correcting codec
//
//  channel   dir   fields                                        role
//  in_ch     in    operation, word_in                            encode or decode request
//  out_ch    out   word_out, uncorrectable, errors_fixed         codeword or corrected data
//
// one transfer per cycle sustained while out_ch is not stalled; eight register stages:
// seven division cells (one dividend bit each) plus the correction and output
// register stage, so a request passes through all seven cells and then the
// output register before its result can transfer on out_ch
// rst_n clears only the valid bits of the stages; payload registers are not reset
// a stall on out_ch holds only the stages that are full; bubbles upstream still
// fill, so input transfers continue until the whole chain is occupied
module bch_15_7_codec_core
    import bch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bch_in_if.sink           in_ch,
    bch_out_if.source        out_ch
);

    stage_t            link  [CELL_COUNT+1];
    logic              vlink [CELL_COUNT+1];
    logic              rlink [CELL_COUNT+1];
    logic [CODE_N-1:0] dividend;
    result_t           result;

    // encode divides data * x^8; decode divides the received word
    assign dividend = (in_ch.operation == OP_DECODE) ? in_ch.word_in
                      : {in_ch.word_in[DATA_W-1:0], {REM_W{1'b0}}};

    // the top eight bits seed the remainder, the low seven are shifted in
    always_comb
    begin
        link[0].op   = op_t'(in_ch.operation);
        link[0].word = dividend;
        link[0].rem  = dividend[CODE_N-1:DATA_W];
        link[0].pend = dividend[DATA_W-1:0];
    end

    assign vlink[0]    = in_ch.valid;
    assign in_ch.ready = rlink[0];

    // chain of division cells, each reducing by g(x) once
    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        bch_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vlink[k]),
            .in_ready  (rlink[k]),
            .in_data   (link[k]),
            .out_valid (vlink[k+1]),
            .out_ready (rlink[k+1]),
            .out_data  (link[k+1])
        );
    end

    // syndrome to error pattern lookup and result register
    bch_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vlink[CELL_COUNT]),
        .in_ready  (rlink[CELL_COUNT]),
        .in_data   (link[CELL_COUNT]),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (result)
    );

    assign out_ch.word_out      = result.word_out;
    assign out_ch.uncorrectable = result.uncorrectable;
    assign out_ch.errors_fixed  = result.errors_fixed;

endmodule
